// File: rtl/lpfr_pkg.sv
// Shared types and constants for the length-prefixed frame receiver.
// Depends on nothing; imported by every file but lpfr_ifs.sv and lpfr_in_stage.
package lpfr_pkg;

  localparam int unsigned HEADER_BYTES = 10;
  localparam logic [7:0] SYNC_BYTE_RESET = 8'hAA;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_GOOD  = 2'd1,
    ST_BAD   = 2'd2,
    ST_SHORT = 2'd3
  } lpfr_status_t;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic [7:0]   byte_index;
    logic         in_payload;
    logic         frame_end;
    lpfr_status_t status;
  } lpfr_result_t;

  // Flow control from the top level to the parser.
  typedef struct packed {
    logic valid;    // input register holds an item
    logic advance;  // that item is consumed at this edge
  } lpfr_flow_t;

endpackage

// File: rtl/lpfr_ifs.sv
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on nothing.
interface lpfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpfr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic       in_payload;
  logic       frame_end;
  logic [1:0] status;

  modport source (output valid, output data_byte, output byte_index, output in_payload,
                  output frame_end, output status, input ready);
  modport sink (input valid, input data_byte, input byte_index, input in_payload,
                input frame_end, input status, output ready);
endinterface

// File: rtl/lpfr_in_stage.sv
// Input register of the frame receiver: holds one received byte.
// Depends on lpfr_ifs.sv.
module lpfr_in_stage (
  input  logic        clk,
  input  logic        rst,
  lpfr_rx_if.sink     rx,
  input  logic        advance,
  output logic        full,
  output logic [7:0]  byte_q
);

  assign rx.ready = !full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

endmodule

// File: rtl/lpfr_parser.sv
// Frame parser: hunt, length and body phases with the subtractive checksum.
// Depends on lpfr_pkg.
module lpfr_parser
  import lpfr_pkg::*;
#(
  parameter int unsigned HDR_BYTES = HEADER_BYTES
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   sync_byte,
  input  logic [7:0]   byte_q,
  input  lpfr_flow_t   flow,
  output lpfr_result_t res,
  output logic         has_result
);

  localparam logic [7:0] HdrLen = 8'(HDR_BYTES);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] position, position_next;
  logic [7:0] frame_length, frame_length_next;

  always_comb begin
    phase_next        = phase;
    running_sum_next  = running_sum;
    position_next     = position;
    frame_length_next = frame_length;
    has_result        = 1'b0;
    res.data_byte     = byte_q;
    res.byte_index    = 8'd0;
    res.in_payload    = 1'b0;
    res.frame_end     = 1'b0;
    res.status        = ST_BUSY;
    case (phase)
      PH_LEN: begin
        has_result     = 1'b1;
        res.byte_index = 8'd1;
        if (byte_q < HdrLen) begin
          // A length shorter than the header aborts the frame.
          res.frame_end = 1'b1;
          res.status    = ST_SHORT;
          phase_next    = PH_HUNT;
        end else begin
          frame_length_next = byte_q;
          running_sum_next  = running_sum - byte_q;
          position_next     = 8'd2;
          phase_next        = PH_BODY;
        end
      end
      PH_BODY: begin
        has_result     = 1'b1;
        res.byte_index = position;
        if (position == frame_length) begin
          res.frame_end = 1'b1;
          res.status    = (byte_q == running_sum) ? ST_GOOD : ST_BAD;
          phase_next    = PH_HUNT;
        end else begin
          res.in_payload   = (position >= HdrLen);
          running_sum_next = running_sum - byte_q;
          position_next    = position + 8'd1;
        end
      end
      default: begin
        // Hunting; the unused phase code falls here as well.
        phase_next = PH_HUNT;
        if (byte_q == sync_byte) begin
          has_result        = 1'b1;
          running_sum_next  = 8'd0;
          position_next     = 8'd1;
          frame_length_next = 8'd0;
          phase_next        = PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      running_sum  <= 8'd0;
      position     <= 8'd0;
      frame_length <= 8'd0;
    end else if (flow.valid && flow.advance) begin
      phase        <= phase_next;
      running_sum  <= running_sum_next;
      position     <= position_next;
      frame_length <= frame_length_next;
    end
  end

endmodule

// File: rtl/lpfr_out_stage.sv
// Result register of the frame receiver, driving the result channel.
// Depends on lpfr_pkg and lpfr_ifs.sv.
module lpfr_out_stage
  import lpfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  lpfr_result_t res_in,
  output logic         space,
  lpfr_res_if.source   result
);

  logic         full;
  lpfr_result_t res_q;

  assign space             = !full || result.ready;
  assign result.valid      = full;
  assign result.data_byte  = res_q.data_byte;
  assign result.byte_index = res_q.byte_index;
  assign result.in_payload = res_q.in_payload;
  assign result.frame_end  = res_q.frame_end;
  assign result.status     = res_q.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (result.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

// File: rtl/length_prefixed_frame_receiver.sv
// Length-prefixed frame receiver: start-byte hunt, length header, 8-bit checksum.
// A byte is taken into the input register and parsed combinationally; any result
// it yields is loaded into the result register. Throughput: one item per cycle
// while the result channel takes results; dropped hunting bytes never wait on it.
// Reset (rst, synchronous): hunting, both registers empty, start byte 0xAA.
// Depends on lpfr_pkg, lpfr_ifs.sv, lpfr_in_stage, lpfr_parser, lpfr_out_stage.
module length_prefixed_frame_receiver
  import lpfr_pkg::*;
#(
  parameter int unsigned HDR_BYTES = HEADER_BYTES
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sync_byte_we,
  input  logic [7:0]  sync_byte_wdata,
  lpfr_rx_if.sink     rx,
  lpfr_res_if.source  result
);

  logic [7:0]   sync_byte;
  logic         in_full;
  logic [7:0]   byte_q;
  logic         advance;
  logic         out_space;
  logic         has_result;
  lpfr_result_t res;
  lpfr_flow_t   flow;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_BYTE_RESET;
    end else if (sync_byte_we) begin
      sync_byte <= sync_byte_wdata;
    end
  end

  // A byte that yields no result never waits on the output side.
  assign advance      = in_full && (!has_result || out_space);
  assign flow.valid   = in_full;
  assign flow.advance = advance;

  lpfr_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .full    (in_full),
    .byte_q  (byte_q)
  );

  lpfr_parser #(
    .HDR_BYTES (HDR_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .sync_byte  (sync_byte),
    .byte_q     (byte_q),
    .flow       (flow),
    .res        (res),
    .has_result (has_result)
  );

  lpfr_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && has_result),
    .res_in (res),
    .space  (out_space),
    .result (result)
  );

endmodule

// File: test/lpfr_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the length-prefixed frame receiver: watches the byte and result channels,
// predicts every frame result and compares it. Depends on lpfr_pkg and lpfr_ifs.sv.
module lpfr_frame_checker
  import lpfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sync_byte_we,
  input  logic [7:0]  sync_byte_wdata,
  lpfr_rx_if          rx,
  lpfr_res_if         result,
  output int unsigned fail_count,
  output int unsigned expected_count
);

  typedef enum logic [1:0] {
    HUNTING,
    AWAIT_LENGTH,
    IN_BODY
  } frame_phase_t;

  frame_phase_t rx_phase;
  logic [7:0]   sync_byte;
  logic [7:0]   checksum;
  logic [7:0]   next_index;
  logic [7:0]   frame_len;
  lpfr_result_t pending_frame_bytes[$];
  int unsigned  mismatches = 0;

  // Advances the frame parse by one byte; returns 1 when the byte is part of a frame.
  function automatic bit predict_frame_byte(input logic [7:0] b, output lpfr_result_t res);
    res = '0;
    res.data_byte = b;
    res.status = ST_BUSY;
    case (rx_phase)
      AWAIT_LENGTH: begin
        res.byte_index = 8'd1;
        if (b < HEADER_BYTES) begin
          res.frame_end = 1'b1;
          res.status = ST_SHORT;
          rx_phase = HUNTING;
        end else begin
          frame_len = b;
          checksum = checksum - b;
          next_index = 8'd2;
          rx_phase = IN_BODY;
        end
        return 1'b1;
      end
      IN_BODY: begin
        res.byte_index = next_index;
        if (next_index == frame_len) begin
          res.frame_end = 1'b1;
          res.status = (b == checksum) ? ST_GOOD : ST_BAD;
          rx_phase = HUNTING;
        end else begin
          res.in_payload = (next_index >= HEADER_BYTES);
          checksum = checksum - b;
          next_index = next_index + 8'd1;
        end
        return 1'b1;
      end
      default: begin
        // While hunting, anything but the start byte is dropped without a result.
        if (b != sync_byte) begin
          rx_phase = HUNTING;
          return 1'b0;
        end
        checksum = 8'd0;
        next_index = 8'd1;
        frame_len = 8'd0;
        rx_phase = AWAIT_LENGTH;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] index,
                                        input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: byte index %0d %s expected %0d, got %0d", $time, index, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    lpfr_result_t seen;
    lpfr_result_t oldest;
    lpfr_result_t predicted;
    if (rst) begin
      rx_phase = HUNTING;
      sync_byte = SYNC_BYTE_RESET;
      checksum = 8'd0;
      next_index = 8'd0;
      frame_len = 8'd0;
      pending_frame_bytes.delete();
    end else begin
      if (result.valid && result.ready) begin
        seen.data_byte = result.data_byte;
        seen.byte_index = result.byte_index;
        seen.in_payload = result.in_payload;
        seen.frame_end = result.frame_end;
        seen.status = lpfr_status_t'(result.status);
        if (pending_frame_bytes.size() == 0) begin
          $display("%0t: result expected none, got byte %0d index %0d status %0d", $time,
                   seen.data_byte, seen.byte_index, result.status);
          mismatches++;
        end else begin
          oldest = pending_frame_bytes.pop_front();
          compare_field("data_byte", oldest.byte_index, oldest.data_byte, seen.data_byte);
          compare_field("byte_index", oldest.byte_index, oldest.byte_index, seen.byte_index);
          compare_field("in_payload", oldest.byte_index, 8'(oldest.in_payload),
                        8'(seen.in_payload));
          compare_field("frame_end", oldest.byte_index, 8'(oldest.frame_end),
                        8'(seen.frame_end));
          compare_field("status", oldest.byte_index, 8'(oldest.status), 8'(result.status));
        end
      end
      if (sync_byte_we) begin
        sync_byte = sync_byte_wdata;
      end
      if (rx.valid && rx.ready) begin
        if (predict_frame_byte(rx.rx_byte, predicted)) begin
          pending_frame_bytes.push_back(predicted);
        end
      end
    end
    fail_count <= mismatches;
    expected_count <= pending_frame_bytes.size();
  end

endmodule

// File: test/length_prefixed_frame_receiver_test.sv
`timescale 1ns / 1ps
// Top of the frame receiver testbench: drives bytes, start byte writes and result stalls,
// and gives the verdict. Depends on lpfr_pkg, lpfr_ifs.sv, the receiver and lpfr_frame_checker.
module length_prefixed_frame_receiver_test;
  import lpfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS   = 140;

  logic        clk = 1'b0;
  logic        rst;
  logic        sync_byte_we;
  logic [7:0]  sync_byte_wdata;
  int unsigned fail_count;
  int unsigned expected_count;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  bit          gaps_enabled = 1'b1;
  logic [7:0]  cur_start = SYNC_BYTE_RESET;

  lpfr_rx_if  rx ();
  lpfr_res_if result ();

  length_prefixed_frame_receiver dut (
    .clk             (clk),
    .rst             (rst),
    .sync_byte_we    (sync_byte_we),
    .sync_byte_wdata (sync_byte_wdata),
    .rx              (rx),
    .result          (result)
  );

  lpfr_frame_checker frame_checker (
    .clk             (clk),
    .rst             (rst),
    .sync_byte_we    (sync_byte_we),
    .sync_byte_wdata (sync_byte_wdata),
    .rx              (rx),
    .result          (result),
    .fail_count      (fail_count),
    .expected_count  (expected_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("length_prefixed_frame_receiver verification failed");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      result.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_enabled && $urandom_range(0, 99) < 25) begin
      result.ready <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (gaps_enabled && $urandom_range(0, 99) < 40) ? idle_length() : 0;
    if (gap != 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    items_sent++;
  endtask

  // Start byte, length and, for a valid length, the body and its checksum.
  task automatic send_frame(input logic [7:0] len, input bit corrupt, input bit start_inside);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'd0;
    send_byte(cur_start);
    send_byte(len);
    if (len < HEADER_BYTES) return;
    sum = sum - len;
    for (int unsigned i = 2; i < len; i++) begin
      b = ((start_inside && i == 2) || $urandom_range(0, 9) == 0) ? cur_start : 8'($urandom);
      sum = sum - b;
      send_byte(b);
    end
    send_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
  endtask

  task automatic send_noise(input int unsigned count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom);
      if (b == cur_start) b = b ^ 8'h01;
      send_byte(b);
    end
  endtask

  // The sender holds off until every predicted result has come out.
  task automatic drain();
    rx.valid <= 1'b0;
    do @(posedge clk); while (expected_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync_byte(input logic [7:0] value);
    drain();
    sync_byte_we <= 1'b1;
    sync_byte_wdata <= value;
    cur_start = value;
    @(posedge clk);
    sync_byte_we <= 1'b0;
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  len;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(HEADER_BYTES, 20))
                                          : 8'($urandom_range(21, 60));
        send_frame(len, $urandom_range(0, 4) == 0, 1'b0);
      end else if (pick < 80) begin
        send_frame(8'($urandom_range(0, HEADER_BYTES - 1)), 1'b0, 1'b0);
      end else if (pick < 92) begin
        send_noise($urandom_range(1, 4));
      end else begin
        // Unfiltered bytes may open or cut into frames at any point.
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    sync_byte_we <= 1'b0;
    sync_byte_wdata <= 8'd0;
    rx.valid <= 1'b0;
    rx.rx_byte <= 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the start byte left at its reset value.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'd0, 1'b0, 1'b0);
    send_frame(8'(HEADER_BYTES - 1), 1'b0, 1'b0);
    send_frame(8'(HEADER_BYTES), 1'b0, 1'b1);
    send_frame(8'(HEADER_BYTES), 1'b1, 1'b0);

    random_traffic(PHASE_ITEMS);
    write_sync_byte(8'h00);
    random_traffic(PHASE_ITEMS);
    write_sync_byte(8'hFF);
    gaps_enabled <= 1'b0;
    random_traffic(PHASE_ITEMS);
    gaps_enabled <= 1'b1;
    write_sync_byte(8'($urandom));
    send_frame(8'd255, 1'b0, 1'b1);
    random_traffic(PHASE_ITEMS);
    write_sync_byte(8'($urandom));
    random_traffic(PHASE_ITEMS);
    write_sync_byte(SYNC_BYTE_RESET);
    random_traffic(PHASE_ITEMS);

    drain();
    if (fail_count == 0 && expected_count == 0) begin
      $display("length_prefixed_frame_receiver verification clean");
    end else begin
      $display("length_prefixed_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
